FILE: rtl/tpbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbs_pkg
// types and constants shared by the two-pass bucket stratifier
// ----------------------------------------------------------------------------
package tpbs_pkg;

  localparam int LEVELS    = 16;
  localparam int VAR_CAP   = 1024;
  localparam int DISEQ_CAP = 1024;
  localparam int ITEM_W    = 32;
  localparam int SLOT_W    = 10;
  localparam int OP_W      = 4;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int USED_W    = $clog2(LEVELS + 1);
  localparam int CNT_W     = $clog2(((VAR_CAP > DISEQ_CAP) ? VAR_CAP : DISEQ_CAP) + 1);
  localparam int VAR_AW    = $clog2(VAR_CAP);
  localparam int DSQ_AW    = $clog2(DISEQ_CAP);

  typedef enum logic [OP_W-1:0] {
    OP_COUNT_VAR = 4'd0,
    OP_COUNT_DSQ = 4'd1,
    OP_FINALIZE  = 4'd2,
    OP_PLACE_VAR = 4'd3,
    OP_PLACE_DSQ = 4'd4,
    OP_READ_VAR  = 4'd5,
    OP_READ_DSQ  = 4'd6,
    OP_LVL_INFO  = 4'd7,
    OP_CLEAR     = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_TOTAL   = 3'd1,
    STAT_LEVEL   = 3'd2,
    STAT_SLICE   = 3'd3,
    STAT_NOT_FIN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN,
    ST_INFO
  } state_e;

  // one row of the level table
  typedef struct packed {
    logic [CNT_W-1:0] var_tally;
    logic [CNT_W-1:0] dsq_tally;
    logic [CNT_W-1:0] var_cursor;
    logic [CNT_W-1:0] dsq_cursor;
    logic [CNT_W-1:0] var_end;
    logic [CNT_W-1:0] dsq_end;
  } lvl_entry_t;

  typedef struct packed {
    status_e           status;
    logic [ITEM_W-1:0] value;
    logic [CNT_W-1:0]  first_var;
    logic [CNT_W-1:0]  first_dsq;
    logic [CNT_W-1:0]  var_cnt;
    logic [CNT_W-1:0]  dsq_cnt;
    logic [USED_W-1:0] levels;
  } res_t;

endpackage

FILE: rtl/two_pass_bucket_stratifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_pass_bucket_stratifier
// counting-sort engine grouping variables and disequalities by level
// ----------------------------------------------------------------------------
// usage
//   a command beat is taken at a rising edge with start high and busy low;
//   operation_i, level_i, item_id_i and slot_i are sampled at that edge.
//   every command gives exactly one result beat: done_o is high for one
//   cycle and the result ports are valid in that cycle. the receiver cannot
//   stall, so results are never held back.
// timing
//   count, place and store read: busy for the level-table or store access,
//   a read-modify-write for count and place; the next command waits.
//   commands rejected up front, clear and unused codes: done_o in the cycle
//   after the command, busy stays low, a command every cycle.
//   finalize walks the whole level table, row by row.
//   level info walks levels 0 to the queried level.
//   the pace is set by the single read port of the level table, whose
//   read data comes in the cycle after the address.
// reset
//   async, active low. level-table rows are cleared through per-row valid
//   bits at once, no sweep. the two item stores are not cleared; clear
//   keeps them too.
// ----------------------------------------------------------------------------
module two_pass_bucket_stratifier
  import tpbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [LVL_W-1:0]  level_i,
  input  logic [ITEM_W-1:0] item_id_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [ITEM_W-1:0] value_o,
  output logic [CNT_W-1:0]  first_var_slot_o,
  output logic [CNT_W-1:0]  first_diseq_slot_o,
  output logic [CNT_W-1:0]  var_count_o,
  output logic [CNT_W-1:0]  diseq_count_o,
  output logic [USED_W-1:0] levels_in_use_o
);

  // control and scalar state
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [ITEM_W-1:0] item_q, item_d;
  logic [LVL_W-1:0]  idx_q, idx_d;      // walk position for finalize and level info
  logic [CNT_W-1:0]  vacc_q, vacc_d;    // running prefix sums
  logic [CNT_W-1:0]  dacc_q, dacc_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]  tot_var_q, tot_var_d;
  logic [CNT_W-1:0]  tot_dsq_q, tot_dsq_d;
  logic              fin_q, fin_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;

  // level table: one memory with a valid bit per row
  lvl_entry_t        lvl_mem [LEVELS];
  logic [LEVELS-1:0] lvl_valid_q;
  lvl_entry_t        lvl_rdata_q;
  logic              lvl_rvalid_q;
  logic [LVL_W-1:0]  lvl_raddr;
  logic [LVL_W-1:0]  lvl_waddr;
  logic              lvl_we;
  lvl_entry_t        lvl_wdata;
  logic              lvl_clear;
  lvl_entry_t        ent;

  // item stores
  logic [ITEM_W-1:0] var_mem [VAR_CAP];
  logic [ITEM_W-1:0] dsq_mem [DISEQ_CAP];
  logic [ITEM_W-1:0] var_rdata_q;
  logic [ITEM_W-1:0] dsq_rdata_q;
  logic              var_we;
  logic              dsq_we;
  logic [VAR_AW-1:0] var_waddr;
  logic [DSQ_AW-1:0] dsq_waddr;

  logic              accept;
  logic              lvl_oob;
  logic              lvl_unused;
  logic [USED_W-1:0] count_used;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign lvl_oob    = int'(level_i) >= LEVELS;
  assign lvl_unused = USED_W'(level_i) >= used_q;
  assign count_used = USED_W'(lvl_q) + USED_W'(1);
  // a row never written since reset or clear reads as all zero
  assign ent        = lvl_rvalid_q ? lvl_rdata_q : '0;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    lvl_d     = lvl_q;
    item_d    = item_q;
    idx_d     = idx_q;
    vacc_d    = vacc_q;
    dacc_d    = dacc_q;
    used_d    = used_q;
    tot_var_d = tot_var_q;
    tot_dsq_d = tot_dsq_q;
    fin_d     = fin_q;
    done_d    = 1'b0;
    res_d     = res_q;
    lvl_raddr = level_i;
    lvl_waddr = lvl_q;
    lvl_we    = 1'b0;
    lvl_wdata = ent;
    lvl_clear = 1'b0;
    var_we    = 1'b0;
    dsq_we    = 1'b0;
    var_waddr = ent.var_cursor[VAR_AW-1:0];
    dsq_waddr = ent.dsq_cursor[DSQ_AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d         = op_e'(operation_i);
          lvl_d        = level_i;
          item_d       = item_id_i;
          idx_d        = '0;
          vacc_d       = '0;
          dacc_d       = '0;
          res_d        = '0;
          res_d.status = STAT_OK;
          res_d.levels = used_q;
          unique case (op_e'(operation_i))
            OP_COUNT_VAR: begin
              if (lvl_oob) begin
                res_d.status = STAT_LEVEL;
                done_d       = 1'b1;
              end else if (tot_var_q >= CNT_W'(VAR_CAP)) begin
                res_d.status = STAT_TOTAL;
                done_d       = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end
            OP_COUNT_DSQ: begin
              if (lvl_oob) begin
                res_d.status = STAT_LEVEL;
                done_d       = 1'b1;
              end else if (tot_dsq_q >= CNT_W'(DISEQ_CAP)) begin
                res_d.status = STAT_TOTAL;
                done_d       = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end
            OP_FINALIZE: begin
              lvl_raddr = '0;
              state_d   = ST_FIN;
            end
            OP_PLACE_VAR, OP_PLACE_DSQ: begin
              if (!fin_q) begin
                res_d.status = STAT_NOT_FIN;
                done_d       = 1'b1;
              end else if (lvl_oob || lvl_unused) begin
                res_d.status = STAT_LEVEL;
                done_d       = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end
            OP_READ_VAR: begin
              if (int'(slot_i) >= VAR_CAP) begin
                res_d.status = STAT_TOTAL;
                done_d       = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end
            OP_READ_DSQ: begin
              if (int'(slot_i) >= DISEQ_CAP) begin
                res_d.status = STAT_TOTAL;
                done_d       = 1'b1;
              end else begin
                state_d = ST_EXEC;
              end
            end
            OP_LVL_INFO: begin
              if (lvl_oob || lvl_unused) begin
                res_d.status = STAT_LEVEL;
                done_d       = 1'b1;
              end else begin
                lvl_raddr = '0;
                state_d   = ST_INFO;
              end
            end
            OP_CLEAR: begin
              // stores keep their contents
              lvl_clear    = 1'b1;
              used_d       = '0;
              tot_var_d    = '0;
              tot_dsq_d    = '0;
              fin_d        = 1'b0;
              res_d.levels = '0;
              done_d       = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // row or store word is back from memory: update and write back the row, or report the store word
      ST_EXEC: begin
        state_d      = ST_IDLE;
        done_d       = 1'b1;
        res_d        = '0;
        res_d.status = STAT_OK;
        res_d.levels = used_q;
        unique case (op_q)
          OP_COUNT_VAR, OP_COUNT_DSQ: begin
            lvl_we = 1'b1;
            if (op_q == OP_COUNT_VAR) begin
              lvl_wdata.var_tally = ent.var_tally + CNT_W'(1);
              tot_var_d           = tot_var_q + CNT_W'(1);
            end else begin
              lvl_wdata.dsq_tally = ent.dsq_tally + CNT_W'(1);
              tot_dsq_d           = tot_dsq_q + CNT_W'(1);
            end
            if (count_used > used_q) begin
              used_d = count_used;
            end
            res_d.levels = (count_used > used_q) ? count_used : used_q;
            fin_d        = 1'b0;
          end
          OP_PLACE_VAR: begin
            if (ent.var_cursor >= ent.var_end || int'(ent.var_cursor) >= VAR_CAP) begin
              res_d.status = STAT_SLICE;
            end else begin
              var_we               = 1'b1;
              lvl_we               = 1'b1;
              lvl_wdata.var_cursor = ent.var_cursor + CNT_W'(1);
            end
          end
          OP_PLACE_DSQ: begin
            if (ent.dsq_cursor >= ent.dsq_end || int'(ent.dsq_cursor) >= DISEQ_CAP) begin
              res_d.status = STAT_SLICE;
            end else begin
              dsq_we               = 1'b1;
              lvl_we               = 1'b1;
              lvl_wdata.dsq_cursor = ent.dsq_cursor + CNT_W'(1);
            end
          end
          OP_READ_VAR: begin
            res_d.value = var_rdata_q;
          end
          OP_READ_DSQ: begin
            res_d.value = dsq_rdata_q;
          end
          default: begin
          end
        endcase
      end

      // prefix sum over every row: cursor and slice end per level
      ST_FIN: begin
        lvl_we               = 1'b1;
        lvl_waddr            = idx_q;
        lvl_wdata.var_cursor = vacc_q;
        lvl_wdata.dsq_cursor = dacc_q;
        lvl_wdata.var_end    = vacc_q + ent.var_tally;
        lvl_wdata.dsq_end    = dacc_q + ent.dsq_tally;
        vacc_d               = vacc_q + ent.var_tally;
        dacc_d               = dacc_q + ent.dsq_tally;
        if (idx_q == LVL_W'(LEVELS - 1)) begin
          fin_d        = 1'b1;
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = STAT_OK;
          res_d.levels = used_q;
        end else begin
          idx_d     = idx_q + LVL_W'(1);
          lvl_raddr = idx_q + LVL_W'(1);
        end
      end

      // sum the tallies below the queried level, then report its own row
      ST_INFO: begin
        if (idx_q == lvl_q) begin
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          res_d           = '0;
          res_d.status    = STAT_OK;
          res_d.first_var = vacc_q;
          res_d.first_dsq = dacc_q;
          res_d.var_cnt   = ent.var_tally;
          res_d.dsq_cnt   = ent.dsq_tally;
          res_d.levels    = used_q;
        end else begin
          vacc_d    = vacc_q + ent.var_tally;
          dacc_d    = dacc_q + ent.dsq_tally;
          idx_d     = idx_q + LVL_W'(1);
          lvl_raddr = idx_q + LVL_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      tot_var_q    <= '0;
      tot_dsq_q    <= '0;
      fin_q        <= 1'b0;
      done_q       <= 1'b0;
      lvl_valid_q  <= '0;
      lvl_rvalid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      tot_var_q    <= tot_var_d;
      tot_dsq_q    <= tot_dsq_d;
      fin_q        <= fin_d;
      done_q       <= done_d;
      lvl_rvalid_q <= lvl_valid_q[lvl_raddr];
      if (lvl_clear) begin
        lvl_valid_q <= '0;
      end else if (lvl_we) begin
        lvl_valid_q[lvl_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    lvl_q  <= lvl_d;
    item_q <= item_d;
    idx_q  <= idx_d;
    vacc_q <= vacc_d;
    dacc_q <= dacc_d;
    res_q  <= res_d;
  end

  // memories, one read and one write port each, registered read data
  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_rdata_q <= lvl_mem[lvl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (var_we) begin
      var_mem[var_waddr] <= item_q;
    end
    var_rdata_q <= var_mem[slot_i[VAR_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (dsq_we) begin
      dsq_mem[dsq_waddr] <= item_q;
    end
    dsq_rdata_q <= dsq_mem[slot_i[DSQ_AW-1:0]];
  end

  assign done_o             = done_q;
  assign status_o           = res_q.status;
  assign value_o            = res_q.value;
  assign first_var_slot_o   = res_q.first_var;
  assign first_diseq_slot_o = res_q.first_dsq;
  assign var_count_o        = res_q.var_cnt;
  assign diseq_count_o      = res_q.dsq_cnt;
  assign levels_in_use_o    = res_q.levels;

  // a result beat always lands while the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");

  // list totals never pass their capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_var_q <= CNT_W'(VAR_CAP)) && (tot_dsq_q <= CNT_W'(DISEQ_CAP)))
    else $error("list total beyond capacity");

  // levels in use never exceed the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(used_q) <= LEVELS)
    else $error("levels in use beyond table depth");

  // stores are only written by a place on finalized lists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (var_we || dsq_we) |-> (state_q == ST_EXEC) && fin_q)
    else $error("store write outside place");

  // clear and a row write never meet
  assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_clear |-> !lvl_we)
    else $error("row write during clear");

  // finalize leaves the lists finalized with its result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && (state_d == ST_IDLE) |=> fin_q && done_o)
    else $error("finalize did not complete");

endmodule
